[rtl/core/tgd_pkg.sv]
package tgd_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 16;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TOUCH   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_TAP     = 3'd3,
        EV_DOUBLE  = 3'd4,
        EV_LONG    = 3'd5
    } t_event;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd1;
    localparam logic [1:0] CFG_LONG_HOLD = 2'd2;
    localparam logic [1:0] CFG_DBL_TAP   = 2'd3;

    localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [CfgW-1:0] LONG_HOLD_RST = 16'd800;
    localparam logic [CfgW-1:0] DBL_TAP_RST   = 16'd400;

    typedef struct packed {
        logic            enable;
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] long_hold_ms;
        logic [CfgW-1:0] dbl_tap_ms;
    } t_cfg;

    typedef struct packed {
        logic             touched;
        logic             touch_edge;
        logic             release_edge;
        logic             single_tap;
        logic             dbl_tap;
        logic             long_hold;
        t_event           final_event;
        logic [TimeW-1:0] held_duration_ms;
    } t_result;

endpackage

[rtl/core/touch_gesture_debouncer.sv]
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// poll in  | i_valid / o_ready    | i_raw_level, i_now_ms
// event out| o_valid / i_ready    | o_touched .. o_final_event, o_held_duration_ms
// config   | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_data
//
// a poll passes through the poll register, then the result register; one poll per cycle sustained while i_ready is high
// the state update is a single pass of subtract and compare at the poll register
// synchronous active-low reset clears control and gesture state, config to defaults
// a stalled result holds the output register; the poll register still fills behind it
module touch_gesture_debouncer
    import tgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_raw_level,
    input  logic [TimeW-1:0] i_now_ms,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_touched,
    output logic             o_touch_edge,
    output logic             o_release_edge,
    output logic             o_single_tap,
    output logic             o_dbl_tap,
    output logic             o_long_hold,
    output logic [2:0]       o_final_event,
    output logic [TimeW-1:0] o_held_duration_ms,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CfgW-1:0]  i_cfg_data
);

    t_cfg             r_cfg;
    logic             r_in_valid, r_in_raw;
    logic [TimeW-1:0] r_in_now;
    logic             r_out_valid;
    t_result          r_out;
    t_result          step_res;
    logic             advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable       <= 1'b1;
            r_cfg.debounce_ms  <= DEBOUNCE_RST;
            r_cfg.long_hold_ms <= LONG_HOLD_RST;
            r_cfg.dbl_tap_ms   <= DBL_TAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:    r_cfg.enable       <= i_cfg_data[0];
                CFG_DEBOUNCE:  r_cfg.debounce_ms  <= i_cfg_data;
                CFG_LONG_HOLD: r_cfg.long_hold_ms <= i_cfg_data;
                CFG_DBL_TAP:   r_cfg.dbl_tap_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // poll register moves on when the result register is free or drains
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_raw <= i_raw_level;
            r_in_now <= i_now_ms;
        end
    end

    tgd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_cfg    (r_cfg),
        .i_raw    (r_in_raw),
        .i_now    (r_in_now),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_touched          = r_out.touched;
    assign o_touch_edge       = r_out.touch_edge;
    assign o_release_edge     = r_out.release_edge;
    assign o_single_tap       = r_out.single_tap;
    assign o_dbl_tap          = r_out.dbl_tap;
    assign o_long_hold        = r_out.long_hold;
    assign o_final_event      = r_out.final_event;
    assign o_held_duration_ms = r_out.held_duration_ms;

endmodule

[rtl/core/tgd_step.sv]
module tgd_step
    import tgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_cfg             i_cfg,
    input  logic             i_raw,
    input  logic [TimeW-1:0] i_now,
    output t_result          o_result
);

    logic             r_prev_raw, r_stable, r_long_fired, r_tap_pending;
    logic [TimeW-1:0] r_settle_start, r_touch_start, r_last_tap;

    logic             n_stable, n_long_fired, n_tap_pending;
    logic [TimeW-1:0] n_settle_start, n_touch_start, n_last_tap;

    logic             raw_changed, accept;
    logic [TimeW-1:0] settle_age, tap_age, hold_age;
    t_result          res;

    always_comb begin
        n_stable       = r_stable;
        n_long_fired   = r_long_fired;
        n_tap_pending  = r_tap_pending;
        n_settle_start = r_settle_start;
        n_touch_start  = r_touch_start;
        n_last_tap     = r_last_tap;

        res              = '0;
        res.final_event  = EV_NONE;

        raw_changed = (i_raw != r_prev_raw);
        settle_age  = i_now - r_settle_start;
        tap_age     = i_now - r_last_tap;
        // a raw change restarts the settle timer, so a poll that changes raw is never accepted
        accept      = !raw_changed && (settle_age > {16'd0, i_cfg.debounce_ms})
                      && (i_raw != r_stable);

        if (i_cfg.enable) begin
            if (raw_changed) begin
                n_settle_start = i_now;
            end
            if (accept) begin
                n_stable = i_raw;
                if (i_raw) begin
                    res.touch_edge  = 1'b1;
                    n_touch_start   = i_now;
                    n_long_fired    = 1'b0;
                    res.final_event = EV_TOUCH;
                end else begin
                    res.release_edge = 1'b1;
                    res.final_event  = EV_RELEASE;
                    if (!r_long_fired) begin
                        if ((tap_age < {16'd0, i_cfg.dbl_tap_ms}) && r_tap_pending) begin
                            n_tap_pending   = 1'b0;
                            res.dbl_tap     = 1'b1;
                            res.final_event = EV_DOUBLE;
                        end else begin
                            n_tap_pending   = 1'b1;
                            n_last_tap      = i_now;
                            res.single_tap  = 1'b1;
                            res.final_event = EV_TAP;
                        end
                    end
                end
            end
        end

        hold_age = i_now - n_touch_start;

        if (i_cfg.enable && n_stable && !n_long_fired
                && (hold_age >= {16'd0, i_cfg.long_hold_ms})) begin
            n_long_fired    = 1'b1;
            res.long_hold   = 1'b1;
            res.final_event = EV_LONG;
        end

        res.touched          = n_stable;
        res.held_duration_ms = n_stable ? hold_age : '0;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw     <= 1'b0;
            r_stable       <= 1'b0;
            r_long_fired   <= 1'b0;
            r_tap_pending  <= 1'b0;
            r_settle_start <= '0;
            r_touch_start  <= '0;
            r_last_tap     <= '0;
        end else if (i_fire && i_cfg.enable) begin
            r_prev_raw     <= i_raw;
            r_stable       <= n_stable;
            r_long_fired   <= n_long_fired;
            r_tap_pending  <= n_tap_pending;
            r_settle_start <= n_settle_start;
            r_touch_start  <= n_touch_start;
            r_last_tap     <= n_last_tap;
        end
    end

    a_edges_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> !(o_result.touch_edge && o_result.release_edge))
        else $error("touch and release edge on one poll");

    a_long_while_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.long_hold) |-> o_result.touched)
        else $error("long touch without debounced touch");

    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cfg.enable) |=> $stable(r_stable) && $stable(r_long_fired)
            && $stable(r_tap_pending))
        else $error("state changed while disabled");

    a_long_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.long_hold) |=> r_long_fired)
        else $error("long touch not latched");

endmodule

[dv/testbench.sv]
module testbench;
    import tgd_pkg::*;

    localparam int unsigned CycleLimit = 400_000;
    localparam int unsigned PressureAt = 300;
    localparam int unsigned PressureLen = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_raw_level;
    logic [TimeW-1:0] i_now_ms;
    logic             o_valid;
    logic             i_ready;
    logic             o_touched;
    logic             o_touch_edge;
    logic             o_release_edge;
    logic             o_single_tap;
    logic             o_dbl_tap;
    logic             o_long_hold;
    logic [2:0]       o_final_event;
    logic [TimeW-1:0] o_held_duration_ms;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CfgW-1:0]  i_cfg_data;

    touch_gesture_debouncer dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow of the configuration registers
    bit              en_r       = 1'b1;
    logic [CfgW-1:0] debounce_r = DEBOUNCE_RST;
    logic [CfgW-1:0] long_r     = LONG_HOLD_RST;
    logic [CfgW-1:0] dtap_r     = DBL_TAP_RST;

    // shadow of the gesture state
    bit               last_raw   = 1'b0;
    bit               stable_lvl = 1'b0;
    logic [TimeW-1:0] settle_t0  = '0;
    logic [TimeW-1:0] press_t0   = '0;
    logic [TimeW-1:0] tap_t0     = '0;
    bit               long_done  = 1'b0;
    bit               tap_armed  = 1'b0;

    t_result     event_q[$];
    t_result     want_r;
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_cnt    = 0;
    bit          tx_busy      = 1'b0;
    bit          rx_busy      = 1'b0;
    bit          pressure_done = 1'b0;
    int unsigned pressure_left = 0;
    int unsigned stall_left    = 0;

    typedef struct {
        bit               is_cfg;
        logic [1:0]       reg_idx;
        logic [CfgW-1:0]  reg_val;
        bit               raw;
        logic [TimeW-1:0] now;
        bit               typed;
        t_result          want;
    } t_stim_row;

    t_stim_row directed[$];

    function automatic t_result debounce_poll(bit raw, logic [TimeW-1:0] now);
        t_result r;
        r = '0;
        if (en_r) begin
            if (raw != last_raw) settle_t0 = now;
            if ((now - settle_t0) > debounce_r && raw != stable_lvl) begin
                stable_lvl = raw;
                if (stable_lvl) begin
                    r.touch_edge = 1'b1;
                    press_t0 = now;
                    long_done = 1'b0;
                    r.final_event = EV_TOUCH;
                end else begin
                    r.release_edge = 1'b1;
                    r.final_event = EV_RELEASE;
                    // a hold that reached long touch is never a tap
                    if (!long_done) begin
                        if ((now - tap_t0) < dtap_r && tap_armed) begin
                            tap_armed = 1'b0;
                            r.dbl_tap = 1'b1;
                            r.final_event = EV_DOUBLE;
                        end else begin
                            tap_armed = 1'b1;
                            tap_t0 = now;
                            r.single_tap = 1'b1;
                            r.final_event = EV_TAP;
                        end
                    end
                end
            end
            if (stable_lvl && !long_done && (now - press_t0) >= long_r) begin
                long_done = 1'b1;
                r.long_hold = 1'b1;
                r.final_event = EV_LONG;
            end
            last_raw = raw;
        end
        r.touched = stable_lvl;
        r.held_duration_ms = stable_lvl ? now - press_t0 : '0;
        return r;
    endfunction

    function automatic t_result mk_result(bit tch, bit te, bit re, bit st, bit dt, bit lt,
                                          t_event ev, logic [TimeW-1:0] held);
        t_result r;
        r.touched = tch;
        r.touch_edge = te;
        r.release_edge = re;
        r.single_tap = st;
        r.dbl_tap = dt;
        r.long_hold = lt;
        r.final_event = ev;
        r.held_duration_ms = held;
        return r;
    endfunction

    function automatic void add_poll(bit raw, logic [TimeW-1:0] now, bit typed = 1'b0,
                                     t_result want = '0);
        t_stim_row row;
        row.is_cfg = 1'b0;
        row.reg_idx = CFG_ENABLE;
        row.reg_val = '0;
        row.raw = raw;
        row.now = now;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [CfgW-1:0] val);
        t_stim_row row;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.raw = 1'b0;
        row.now = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed.push_back(row);
    endfunction

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned pick_hold();
        case ($urandom_range(0, 3))
            0: return debounce_r + $urandom_range(0, 3);
            1: return long_r + $urandom_range(0, 30);
            2: return dtap_r + $urandom_range(0, 30);
            default: return debounce_r + $urandom_range(1, 300);
        endcase
    endfunction

    function automatic logic [CfgW-1:0] pick_cfg(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            default: return CfgW'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic void check_field(string name, logic [TimeW-1:0] want,
                                        logic [TimeW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_poll(bit raw, logic [TimeW-1:0] now, bit typed = 1'b0,
                             t_result want = '0);
        int unsigned gap;
        gap = (tx_busy && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_raw_level <= raw;
        i_now_ms <= now;
        do @(posedge i_clk); while (!o_ready);
        if (typed) begin
            void'(debounce_poll(raw, now));
            event_q.push_back(want);
        end else begin
            event_q.push_back(debounce_poll(raw, now));
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:    en_r = val[0];
            CFG_DEBOUNCE:  debounce_r = val;
            CFG_LONG_HOLD: long_r = val;
            CFG_DBL_TAP:   dtap_r = val;
            default: ;
        endcase
    endtask

    // gestures: a level change with some bounce, then steady polls past a chosen hold
    task automatic run_phase(int unsigned n_polls);
        logic [TimeW-1:0] t;
        bit               lvl;
        int unsigned      hold;
        int unsigned      step;
        int unsigned      held;
        int unsigned      d;
        int unsigned      n;
        t = $urandom;
        if ($urandom_range(0, 2) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 300000);
        lvl = 1'b0;
        n = 0;
        while (n < n_polls) begin
            lvl = !lvl;
            hold = pick_hold();
            step = hold / $urandom_range(2, 5) + 1;
            repeat ($urandom_range(0, 2)) begin
                t += $urandom_range(0, step);
                send_poll(1'($urandom_range(0, 1)), t);
                n++;
            end
            held = 0;
            while (held <= hold) begin
                d = $urandom_range(1, step);
                t += d;
                held += d;
                if ($urandom_range(0, 19) == 0) send_poll(1'($urandom_range(0, 1)), $urandom);
                else send_poll(lvl, t);
                n++;
            end
        end
    endtask

    // receiver side: random stalls, calm stretches and one long hold-off
    always @(negedge i_clk) begin
        if (cycle_cnt % 200 == 0) rx_busy = ($urandom_range(0, 2) != 0);
        if (!pressure_done && results_seen >= PressureAt) begin
            pressure_done = 1'b1;
            pressure_left = PressureLen;
        end
        if (pressure_left > 0) begin
            pressure_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (rx_busy && $urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (event_q.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatches++;
            end else begin
                want_r = event_q.pop_front();
                check_field("touched", TimeW'(want_r.touched), TimeW'(o_touched));
                check_field("touch_edge", TimeW'(want_r.touch_edge), TimeW'(o_touch_edge));
                check_field("release_edge", TimeW'(want_r.release_edge),
                            TimeW'(o_release_edge));
                check_field("single_tap", TimeW'(want_r.single_tap), TimeW'(o_single_tap));
                check_field("dbl_tap", TimeW'(want_r.dbl_tap), TimeW'(o_dbl_tap));
                check_field("long_hold", TimeW'(want_r.long_hold), TimeW'(o_long_hold));
                check_field("final_event", TimeW'(want_r.final_event), TimeW'(o_final_event));
                check_field("held_duration_ms", want_r.held_duration_ms, o_held_duration_ms);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_raw_level = 1'b0;
        i_now_ms = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ENABLE;
        i_cfg_data = '0;

        // reset defaults: debounce 20, long touch 800, double tap 400
        add_poll(1'b0, 0, 1'b1,
                 mk_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, 0));
        add_poll(1'b1, 100, 1'b1,
                 mk_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, 0));
        // exactly the debounce time is not enough
        add_poll(1'b1, 120, 1'b1,
                 mk_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, 0));
        add_poll(1'b1, 121, 1'b1,
                 mk_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EV_TOUCH, 0));
        add_poll(1'b0, 200);
        add_poll(1'b0, 221);
        // second tap inside the window
        add_poll(1'b1, 250);
        add_poll(1'b1, 271);
        add_poll(1'b0, 300);
        add_poll(1'b0, 321);
        // long touch one ms short, then reached, then a release with no tap
        add_poll(1'b1, 1000);
        add_poll(1'b1, 1021);
        add_poll(1'b1, 1820);
        add_poll(1'b1, 1821);
        add_poll(1'b0, 1900);
        add_poll(1'b0, 1921);
        // settle timer across the timestamp wrap
        add_poll(1'b1, 32'hFFFF_FFF0);
        add_poll(1'b1, 32'h0000_0005);
        add_poll(1'b1, 32'hFFFF_FFFF);
        add_reg(CFG_LONG_HOLD, 16'd0);
        add_reg(CFG_DEBOUNCE, 16'd0);
        add_poll(1'b0, 3000);
        add_poll(1'b0, 3001);
        add_poll(1'b1, 3002);
        // zero long-touch time: touch and long touch on one poll
        add_poll(1'b1, 3003, 1'b1,
                 mk_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, EV_LONG, 0));
        add_reg(CFG_ENABLE, 16'd0);
        add_poll(1'b0, 5000, 1'b1,
                 mk_result(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE, 1997));
        add_reg(CFG_ENABLE, 16'd1);
        add_poll(1'b0, 5001);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                wait_idle();
                write_reg(directed[k].reg_idx, directed[k].reg_val);
            end else begin
                send_poll(directed[k].raw, directed[k].now, directed[k].typed,
                          directed[k].want);
            end
        end

        for (int p = 0; p < 11; p++) begin
            wait_idle();
            tx_busy = (p != 2) && ($urandom_range(0, 3) != 0);
            case (p)
                0: begin
                    write_reg(CFG_DEBOUNCE, '1);
                    write_reg(CFG_LONG_HOLD, '1);
                    write_reg(CFG_DBL_TAP, '1);
                end
                1: begin
                    write_reg(CFG_DEBOUNCE, '0);
                    write_reg(CFG_LONG_HOLD, '0);
                    write_reg(CFG_DBL_TAP, '0);
                end
                default: begin
                    write_reg(CFG_DEBOUNCE, pick_cfg(1, 50));
                    write_reg(CFG_LONG_HOLD, pick_cfg(50, 2000));
                    write_reg(CFG_DBL_TAP, pick_cfg(50, 1000));
                end
            endcase
            write_reg(CFG_ENABLE, (p == 5) ? 16'd0 : 16'd1);
            run_phase((p == 5) ? 20 : 100);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tgd_pkg.sv
rtl/core/tgd_step.sv
rtl/core/touch_gesture_debouncer.sv
dv/testbench.sv
